### hw/rtl/rtnp_pkg.sv
package rtnp_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_TEMPO_BPM        = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_OCTAVE   = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_DURATION = 2'd2;

  // one input item: a text character
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } rtnp_in_t;

  // one result item
  typedef struct packed {
    logic [13:0] freq_hz;
    logic [18:0] length_ms;
    logic        is_rest;
    logic        melody_end;
  } rtnp_out_t;

  // classified note handed from front to back
  typedef struct packed {
    logic [13:0] freq_hz;
    logic [5:0]  duration;
    logic        dotted;
    logic        is_rest;
    logic        melody_end;
  } rtnp_note_t;

  // back end status
  typedef struct packed {
    logic start;
    logic done;
  } rtnp_back_stat_t;

  // base octave tone table
  function automatic logic [9:0] tone_hz(input logic [3:0] idx);
    logic [9:0] hz;
    case (idx)
      4'd0:    hz = 10'd261;
      4'd1:    hz = 10'd277;
      4'd2:    hz = 10'd294;
      4'd3:    hz = 10'd311;
      4'd4:    hz = 10'd330;
      4'd5:    hz = 10'd349;
      4'd6:    hz = 10'd370;
      4'd7:    hz = 10'd392;
      4'd8:    hz = 10'd415;
      4'd9:    hz = 10'd440;
      4'd10:   hz = 10'd466;
      4'd11:   hz = 10'd494;
      4'd12:   hz = 10'd523;
      default: hz = 10'd0;
    endcase
    return hz;
  endfunction

  // table index of a..g without sharp
  function automatic logic [3:0] natural_idx(input logic [2:0] letter);
    logic [3:0] idx;
    case (letter)
      3'd0:    idx = 4'd9;
      3'd1:    idx = 4'd11;
      3'd2:    idx = 4'd0;
      3'd3:    idx = 4'd2;
      3'd4:    idx = 4'd4;
      3'd5:    idx = 4'd5;
      3'd6:    idx = 4'd7;
      default: idx = 4'd0;
    endcase
    return idx;
  endfunction

  // table index of a..g with sharp
  function automatic logic [3:0] sharp_idx(input logic [2:0] letter);
    logic [3:0] idx;
    case (letter)
      3'd0:    idx = 4'd10;
      3'd1:    idx = 4'd12;
      3'd2:    idx = 4'd1;
      3'd3:    idx = 4'd3;
      3'd4:    idx = 4'd5;
      3'd5:    idx = 4'd6;
      3'd6:    idx = 4'd8;
      default: idx = 4'd0;
    endcase
    return idx;
  endfunction

endpackage

### hw/rtl/rtnp_front.sv
module rtnp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  rtnp_pkg::rtnp_in_t  char_i,
  input  logic [3:0]          default_octave_i,
  input  logic [5:0]          default_duration_i,
  output logic                note_push_o,
  output rtnp_pkg::rtnp_note_t note_o
);
  import rtnp_pkg::*;

  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharA     = 8'h61;
  localparam logic [7:0] CharG     = 8'h67;
  localparam logic [7:0] CharP     = 8'h70;
  localparam logic [2:0] LetterRest = 3'd7;

  logic [5:0] dur_acc_q, dur_acc_d;
  logic [3:0] oct_acc_q, oct_acc_d;
  logic [2:0] letter_q, letter_d;
  logic       letter_seen_q, letter_seen_d;
  logic       sharp_q, sharp_d;
  logic       dot_q, dot_d;
  logic       oct_seen_q, oct_seen_d;

  logic       is_digit, is_letter, close;
  logic [3:0] digit;
  logic [9:0] dur_calc;
  logic [7:0] oct_calc;
  logic [3:0] oct_dflt, oct_use, tbl_idx;
  logic [2:0] oct_shift;
  logic [5:0] dur_use;

  // classify the character and update the note fields
  always_comb begin
    is_digit  = (char_i.char_code >= CharZero) && (char_i.char_code <= CharNine);
    is_letter = ((char_i.char_code >= CharA) && (char_i.char_code <= CharG)) ||
                (char_i.char_code == CharP);
    close     = char_i.end_of_text || (char_i.char_code == CharComma);
    digit     = char_i.char_code[3:0];
    dur_calc  = 10'(dur_acc_q) * 10'd10 + 10'(digit);
    oct_calc  = 8'(oct_acc_q) * 8'd10 + 8'(digit);

    dur_acc_d     = dur_acc_q;
    oct_acc_d     = oct_acc_q;
    letter_d      = letter_q;
    letter_seen_d = letter_seen_q;
    sharp_d       = sharp_q;
    dot_d         = dot_q;
    oct_seen_d    = oct_seen_q;

    if (is_digit) begin
      if (!letter_seen_q) begin
        dur_acc_d = (dur_calc > 10'd63) ? 6'd63 : dur_calc[5:0];
      end else begin
        oct_acc_d  = (oct_calc > 8'd15) ? 4'd15 : oct_calc[3:0];
        oct_seen_d = 1'b1;
      end
    end else if (is_letter) begin
      if (!letter_seen_q) begin
        letter_d      = (char_i.char_code == CharP) ? LetterRest
                                                    : 3'(char_i.char_code - CharA);
        letter_seen_d = 1'b1;
      end
    end else if (char_i.char_code == CharHash) begin
      sharp_d = 1'b1;
    end else if (char_i.char_code == CharDot) begin
      dot_d = 1'b1;
    end
  end

  // resolve octave, duration and tone of the closed note
  always_comb begin
    if (default_octave_i < 4'd4) begin
      oct_dflt = 4'd4;
    end else if (default_octave_i > 4'd8) begin
      oct_dflt = 4'd8;
    end else begin
      oct_dflt = default_octave_i;
    end
    if (oct_seen_d && (oct_acc_d >= 4'd4) && (oct_acc_d <= 4'd8)) begin
      oct_use = oct_acc_d;
    end else begin
      oct_use = oct_dflt;
    end
    oct_shift = 3'(oct_use - 4'd4);

    if (dur_acc_d != 6'd0) begin
      dur_use = dur_acc_d;
    end else if (default_duration_i != 6'd0) begin
      dur_use = default_duration_i;
    end else begin
      dur_use = 6'd1;
    end

    tbl_idx = sharp_d ? sharp_idx(letter_d) : natural_idx(letter_d);

    note_o.freq_hz    = '0;
    if (letter_seen_d && (letter_d != LetterRest)) begin
      note_o.freq_hz = 14'(tone_hz(tbl_idx)) << oct_shift;
    end
    note_o.duration   = dur_use;
    note_o.dotted     = dot_d;
    note_o.is_rest    = letter_seen_d && (letter_d == LetterRest);
    note_o.melody_end = char_i.end_of_text;
  end

  assign note_push_o = accept_i && close;

  // note field registers, cleared after each closed note
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_acc_q     <= '0;
      oct_acc_q     <= '0;
      letter_q      <= '0;
      letter_seen_q <= 1'b0;
      sharp_q       <= 1'b0;
      dot_q         <= 1'b0;
      oct_seen_q    <= 1'b0;
    end else if (accept_i) begin
      if (close) begin
        dur_acc_q     <= '0;
        oct_acc_q     <= '0;
        letter_q      <= '0;
        letter_seen_q <= 1'b0;
        sharp_q       <= 1'b0;
        dot_q         <= 1'b0;
        oct_seen_q    <= 1'b0;
      end else begin
        dur_acc_q     <= dur_acc_d;
        oct_acc_q     <= oct_acc_d;
        letter_q      <= letter_d;
        letter_seen_q <= letter_seen_d;
        sharp_q       <= sharp_d;
        dot_q         <= dot_d;
        oct_seen_q    <= oct_seen_d;
      end
    end
  end

endmodule

### hw/rtl/rtnp_queue.sv
module rtnp_queue #(
  parameter int Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rtnp_pkg::rtnp_note_t data_i,
  input  logic                 pop_i,
  output rtnp_pkg::rtnp_note_t data_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import rtnp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  rtnp_note_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // storage write
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/rtnp_back.sv
module rtnp_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [9:0]              tempo_bpm_i,
  input  logic                    note_empty_i,
  input  rtnp_pkg::rtnp_note_t    note_i,
  output logic                    note_pop_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output rtnp_pkg::rtnp_out_t     out_o,
  output rtnp_pkg::rtnp_back_stat_t stat_o
);
  import rtnp_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv1 = 2'd1;
  localparam logic [1:0] StDiv2 = 2'd2;
  localparam logic [1:0] StDone = 2'd3;
  localparam logic [15:0] MsPerMinute = 16'd60000;

  logic [1:0]  state_q, state_d;
  logic [3:0]  step_q;
  logic [15:0] dvd_q;
  logic [9:0]  dvs_q;
  logic [9:0]  rem_q;
  rtnp_note_t  note_q;
  logic        out_valid_q;
  rtnp_out_t   out_q;

  logic        start, slot_free, load_out, qbit;
  logic [10:0] rem_sh;
  logic [9:0]  rem_nx;
  logic [9:0]  tempo_eff;
  logic [18:0] len;

  assign tempo_eff = (tempo_bpm_i == '0) ? 10'd1 : tempo_bpm_i;
  assign slot_free = !out_valid_q || pop_i;
  assign start     = (state_q == StIdle) && !note_empty_i;
  assign load_out  = (state_q == StDone) && slot_free;
  assign note_pop_o = start;

  // one restoring division step
  always_comb begin
    rem_sh = {rem_q, dvd_q[15]};
    qbit   = (rem_sh >= {1'b0, dvs_q});
    rem_nx = qbit ? 10'(rem_sh - {1'b0, dvs_q}) : rem_sh[9:0];
  end

  // length with dot extension: q*4 plus q*2
  assign len = {1'b0, dvd_q, 2'b00} + (note_q.dotted ? {2'b00, dvd_q, 1'b0} : 19'd0);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (start) state_d = StDiv1;
      StDiv1: if (step_q == 4'd15) state_d = StDiv2;
      StDiv2: if (step_q == 4'd15) state_d = StDone;
      StDone: if (slot_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == StDiv1) || (state_q == StDiv2)) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // divider datapath, quotient shifts into the dividend register
  always_ff @(posedge clk_i) begin
    if (start) begin
      note_q <= note_i;
      dvd_q  <= MsPerMinute;
      dvs_q  <= tempo_eff;
      rem_q  <= '0;
    end else if ((state_q == StDiv1) && (step_q == 4'd15)) begin
      dvd_q <= {dvd_q[14:0], qbit};
      dvs_q <= {4'd0, note_q.duration};
      rem_q <= '0;
    end else if ((state_q == StDiv1) || (state_q == StDiv2)) begin
      dvd_q <= {dvd_q[14:0], qbit};
      rem_q <= rem_nx;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.freq_hz    <= note_q.freq_hz;
      out_q.length_ms  <= len;
      out_q.is_rest    <= note_q.is_rest;
      out_q.melody_end <= note_q.melody_end;
    end
  end

  assign empty_o      = !out_valid_q;
  assign out_o        = out_q;
  assign stat_o.start = start;
  assign stat_o.done  = load_out;

endmodule

### hw/rtl/ringtone_note_parser_unit.sv
// Ringtone note parser: takes the note section of a ringtone text one
// character per item and gives one result item per closed note.
// Input channel: push / full. A character is taken when push is high and
// full is low; up to one character per cycle while the note queue has room.
// Result channel: empty / pop. The oldest result sits on out_data_o while
// empty is low and leaves on a cycle with pop high.
// Config channel: cfg_valid_i / cfg_ready_o, always ready; index 0 tempo,
// 1 default octave, 2 default duration. Write only while the block is idle.
// Result path: the closing character (comma or end of text) puts a note
// into the note queue, then a shared one-bit-per-cycle divider runs 16
// steps for 60000/tempo and 16 steps for the division by duration, then
// the result is registered in the result register. The divider takes a
// new note only after it has finished the last; characters are taken
// every cycle until QueueDepth closed notes wait.
// When the receiver stalls, the held result blocks the divider, the queue
// fills and full rises. Reset empties the queue and result register and
// loads tempo 63, default octave 6, default duration 4.
module ringtone_note_parser_unit #(
  parameter int QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  rtnp_pkg::rtnp_in_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output rtnp_pkg::rtnp_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [9:0]          cfg_data_i
);
  import rtnp_pkg::*;

  logic [9:0] tempo_q;
  logic [3:0] def_oct_q;
  logic [5:0] def_dur_q;

  logic            accept, q_push, q_pop, q_full, q_empty;
  rtnp_note_t      note_in, note_out;
  rtnp_back_stat_t bk_stat;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !q_full;
  assign full        = q_full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q   <= 10'd63;
      def_oct_q <= 4'd6;
      def_dur_q <= 6'd4;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TEMPO_BPM:        tempo_q   <= cfg_data_i;
        CFG_DEFAULT_OCTAVE:   def_oct_q <= cfg_data_i[3:0];
        CFG_DEFAULT_DURATION: def_dur_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  rtnp_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .char_i             (in_data_i),
    .default_octave_i   (def_oct_q),
    .default_duration_i (def_dur_q),
    .note_push_o        (q_push),
    .note_o             (note_in)
  );

  rtnp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (note_in),
    .pop_i   (q_pop),
    .data_o  (note_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rtnp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tempo_bpm_i  (tempo_q),
    .note_empty_i (q_empty),
    .note_i       (note_out),
    .note_pop_o   (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_o        (out_data_o),
    .stat_o       (bk_stat)
  );

`ifndef SYNTH
  // back end only starts on a waiting note
  a_start_needs_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.start |-> !q_empty)
    else $error("back end started with an empty note queue");

  // a result appears only after the divider has finished
  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(bk_stat.done))
    else $error("result appeared without a finished division");

  // a rest never carries a tone
  a_rest_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.is_rest) |-> (out_data_o.freq_hz == '0))
    else $error("rest result with nonzero frequency");
`endif

endmodule
